/* design/accel_tilt_angles_macros.svh */
// Assertion macros used by the checker
`ifndef ACCEL_TILT_ANGLES_MACROS_SVH
`define ACCEL_TILT_ANGLES_MACROS_SVH

`define ATL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`define ATL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ATL_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

/* design/atl_pkg.sv */
package atl_pkg;

	localparam int ANG_W = 24;
	localparam int GAIN_W = 10;
	localparam int OUT_W = 18;
	localparam int TABLE_LEN = 24;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd358;

	typedef struct packed {
		logic zero;
		logic pos;
		logic neg;
	} atl_sign_t;

	localparam logic signed [ANG_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
		24'sd2949120, 24'sd1740967, 24'sd919879, 24'sd466945,
		24'sd234379, 24'sd117304, 24'sd58666, 24'sd29335,
		24'sd14668, 24'sd7334, 24'sd3667, 24'sd1833,
		24'sd917, 24'sd458, 24'sd229, 24'sd115,
		24'sd57, 24'sd29, 24'sd14, 24'sd7,
		24'sd4, 24'sd2, 24'sd1, 24'sd0
	};

	localparam logic signed [ANG_W-1:0] RIGHT_ANGLE_Q16 = 24'sd5898240;

endpackage

/* design/accel_tilt_angles.sv */
// channel   ports                                  handshake
// sample    accel_x, accel_y, accel_z              start, busy (busy stays low)
// gain      gain_wdata                             gain_we
// angles    pitch_angle, roll_angle                done, one cycle
//
// One sample enters every cycle; results pass through the input, square and sum registers,
// the square root cells (one root bit each), the CORDIC cells and the gain and output registers.
// Reset clears all valid bits and loads the gain with 1.4.
// The receiver cannot stall; done strobes each result for exactly one cycle.
module accel_tilt_angles #(
	parameter int CORDIC_STAGES = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	input  logic                          gain_we,
	input  logic [atl_pkg::GAIN_W-1:0]    gain_wdata,
	output logic                          done,
	output logic signed [atl_pkg::OUT_W-1:0] pitch_angle,
	output logic signed [atl_pkg::OUT_W-1:0] roll_angle
);
	import atl_pkg::*;

	localparam int W = SAMPLE_WIDTH;
	localparam int M = SAMPLE_WIDTH + 8;
	localparam int DW = M + 2;
	localparam int C = CORDIC_STAGES;
	localparam int PW = ANG_W + GAIN_W + 1;

	function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PW-1:0] p);
		logic signed [PW:0]     r;
		logic signed [PW-16:0]  v;
		r = {p[PW-1], p} + (PW+1)'(32768);
		v = r[PW:16];
		if (v > (PW-15)'(131071))
			return OUT_W'(131071);
		else if (v < -(PW-15)'(131072))
			return -OUT_W'(131072);
		else
			return v[OUT_W-1:0];
	endfunction

	logic [GAIN_W-1:0] tilt_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_gain_q <= GAIN_RESET;
		end else if (gain_we) begin
			tilt_gain_q <= gain_wdata;
		end
	end

	assign busy = 1'b0;

	logic                v_s1, v_s2, v_s3;
	logic signed [W-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, x_s3, y_s3;
	logic signed [2*W-1:0] xx, yy, zz;
	logic [2*W-1:0]      x2_s2, y2_s2, z2_s2, sqp_s3, sqr_s3;

	assign xx = x_s1 * x_s1;
	assign yy = y_s1 * y_s1;
	assign zz = z_s1 * z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= accel_x;
		y_s1 <= accel_y;
		z_s1 <= accel_z;
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		x2_s2 <= xx;
		y2_s2 <= yy;
		z2_s2 <= zz;
		x_s3 <= x_s2;
		y_s3 <= y_s2;
		sqp_s3 <= y2_s2 + z2_s2;
		sqr_s3 <= x2_s2 + z2_s2;
	end

	logic                     sq_v    [2][M+1];
	atl_sign_t                sq_sg   [2][M+1];
	logic [W-1:0]             sq_num  [2][M+1];
	logic [2*M-1:0]           sq_op   [2][M+1];
	logic [M+1:0]             sq_rem  [2][M+1];
	logic [M-1:0]             sq_root [2][M+1];

	logic                     cd_v    [2][C+1];
	atl_sign_t                cd_sg   [2][C+1];
	logic signed [DW-1:0]     cd_px   [2][C+1];
	logic signed [DW-1:0]     cd_py   [2][C+1];
	logic signed [ANG_W-1:0]  cd_ang  [2][C+1];

	logic signed [ANG_W-1:0]  ang_sel [2];
	logic signed [PW-1:0]     prod_s4 [2];
	logic                     v_s4;

	genvar l, k;
	generate
		for (l = 0; l < 2; l++) begin : g_lane
			logic [2*W-1:0]      sq_in;
			logic signed [W-1:0] num_in;

			assign sq_in = (l == 0) ? sqp_s3 : sqr_s3;
			assign num_in = (l == 0) ? x_s3 : y_s3;

			assign sq_v[l][0] = v_s3;
			assign sq_sg[l][0].zero = (sq_in == '0);
			assign sq_sg[l][0].pos = !num_in[W-1] && (num_in != '0);
			assign sq_sg[l][0].neg = num_in[W-1];
			assign sq_num[l][0] = num_in;
			assign sq_op[l][0] = {sq_in, 16'b0};
			assign sq_rem[l][0] = '0;
			assign sq_root[l][0] = '0;

			for (k = 0; k < M; k++) begin : g_sqrt
				atl_sqrt_cell #(.W(W), .M(M)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.in_valid (sq_v[l][k]),
					.in_sign  (sq_sg[l][k]),
					.in_num   (sq_num[l][k]),
					.in_op    (sq_op[l][k]),
					.in_rem   (sq_rem[l][k]),
					.in_root  (sq_root[l][k]),
					.out_valid(sq_v[l][k+1]),
					.out_sign (sq_sg[l][k+1]),
					.out_num  (sq_num[l][k+1]),
					.out_op   (sq_op[l][k+1]),
					.out_rem  (sq_rem[l][k+1]),
					.out_root (sq_root[l][k+1])
				);
			end

			assign cd_v[l][0] = sq_v[l][M];
			assign cd_sg[l][0] = sq_sg[l][M];
			assign cd_px[l][0] = {2'b00, sq_root[l][M]};
			assign cd_py[l][0] = {{2{sq_num[l][M][W-1]}}, sq_num[l][M], 8'b0};
			assign cd_ang[l][0] = '0;

			for (k = 0; k < C; k++) begin : g_cordic
				atl_cordic_cell #(.STAGE(k), .DW(DW)) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.in_valid (cd_v[l][k]),
					.in_sign  (cd_sg[l][k]),
					.in_px    (cd_px[l][k]),
					.in_py    (cd_py[l][k]),
					.in_ang   (cd_ang[l][k]),
					.out_valid(cd_v[l][k+1]),
					.out_sign (cd_sg[l][k+1]),
					.out_px   (cd_px[l][k+1]),
					.out_py   (cd_py[l][k+1]),
					.out_ang  (cd_ang[l][k+1])
				);
			end

			always_comb begin
				if (!cd_sg[l][C].zero)
					ang_sel[l] = cd_ang[l][C];
				else if (cd_sg[l][C].pos)
					ang_sel[l] = RIGHT_ANGLE_Q16;
				else if (cd_sg[l][C].neg)
					ang_sel[l] = -RIGHT_ANGLE_Q16;
				else
					ang_sel[l] = '0;
			end

			always_ff @(posedge clk) begin
				prod_s4[l] <= ang_sel[l] * $signed({1'b0, tilt_gain_q});
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= cd_v[0][C];
			done <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		pitch_angle <= round_sat(prod_s4[0]);
		roll_angle <= round_sat(prod_s4[1]);
	end

endmodule

/* design/atl_sqrt_cell.sv */
module atl_sqrt_cell #(
	parameter int W = 16,
	parameter int M = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  atl_pkg::atl_sign_t in_sign,
	input  logic [W-1:0]      in_num,
	input  logic [2*M-1:0]    in_op,
	input  logic [M+1:0]      in_rem,
	input  logic [M-1:0]      in_root,
	output logic              out_valid,
	output atl_pkg::atl_sign_t out_sign,
	output logic [W-1:0]      out_num,
	output logic [2*M-1:0]    out_op,
	output logic [M+1:0]      out_rem,
	output logic [M-1:0]      out_root
);
	import atl_pkg::*;

	logic [M+1:0] rem_sh;
	logic [M+1:0] trial;
	logic         ge;

	assign rem_sh = {in_rem[M-1:0], in_op[2*M-1:2*M-2]};
	assign trial = {in_root, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_sign <= in_sign;
		out_num <= in_num;
		out_op <= {in_op[2*M-3:0], 2'b00};
		out_rem <= ge ? (rem_sh - trial) : rem_sh;
		out_root <= {in_root[M-2:0], ge};
	end

endmodule

/* design/atl_cordic_cell.sv */
module atl_cordic_cell #(
	parameter int STAGE = 0,
	parameter int DW = 26
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  atl_pkg::atl_sign_t             in_sign,
	input  logic signed [DW-1:0]           in_px,
	input  logic signed [DW-1:0]           in_py,
	input  logic signed [atl_pkg::ANG_W-1:0] in_ang,
	output logic                           out_valid,
	output atl_pkg::atl_sign_t             out_sign,
	output logic signed [DW-1:0]           out_px,
	output logic signed [DW-1:0]           out_py,
	output logic signed [atl_pkg::ANG_W-1:0] out_ang
);
	import atl_pkg::*;

	logic signed [DW-1:0] px_sh;
	logic signed [DW-1:0] py_sh;
	logic                 turn_down;

	assign px_sh = in_px >>> STAGE;
	assign py_sh = in_py >>> STAGE;
	assign turn_down = !in_py[DW-1] && (in_py != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_sign <= in_sign;
		if (turn_down) begin
			out_px <= in_px + py_sh;
			out_py <= in_py - px_sh;
			out_ang <= in_ang + ATAN_Q16[STAGE];
		end else begin
			out_px <= in_px - py_sh;
			out_py <= in_py + px_sh;
			out_ang <= in_ang - ATAN_Q16[STAGE];
		end
	end

endmodule

/* design/atl_checker.sv */
`include "accel_tilt_angles_macros.svh"

module atl_checker #(
	parameter int LAT = 45,
	parameter int W = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic signed [W-1:0]   accel_x,
	input logic signed [W-1:0]   accel_y,
	input logic signed [W-1:0]   accel_z,
	input logic signed [17:0]    pitch_angle,
	input logic signed [17:0]    roll_angle
);

	`ATL_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "busy raised")
	`ATL_ASSERT_IMP(a_done_has_word, clk, arst_n, done, $past(start, LAT), "done without word")
	`ATL_ASSERT_DLY(a_zero_sample, clk, arst_n,
		start && accel_x == 0 && accel_y == 0 && accel_z == 0, LAT,
		done && pitch_angle == 0 && roll_angle == 0, "zero sample gave nonzero angle")

endmodule

bind accel_tilt_angles atl_checker #(
	.LAT(SAMPLE_WIDTH + CORDIC_STAGES + 13),
	.W(SAMPLE_WIDTH)
) u_atl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.accel_x    (accel_x),
	.accel_y    (accel_y),
	.accel_z    (accel_z),
	.pitch_angle(pitch_angle),
	.roll_angle (roll_angle)
);

/* bench/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16 + 16 + 13;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 950;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} sample_t;

	typedef struct {
		logic signed [17:0] pitch;
		logic signed [17:0] roll;
	} angles_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] accel_x = '0;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic gain_we = 1'b0;
	logic [atl_pkg::GAIN_W-1:0] gain_wdata = '0;
	logic done;
	logic signed [17:0] pitch_angle;
	logic signed [17:0] roll_angle;

	sample_t pending_samples[$];
	angles_t expected_angles[$];
	logic [9:0] model_gain;
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	bit feed_on = 1'b0;

	accel_tilt_angles u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.gain_we(gain_we), .gain_wdata(gain_wdata), .done(done),
		.pitch_angle(pitch_angle), .roll_angle(roll_angle)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0) return v >>> s;
		return -1 - ((-1 - v) >>> s);
	endfunction

	function automatic longint root_q8(longint n);
		longint res, b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	function automatic longint atan_q16(int i);
		return longint'(atl_pkg::ATAN_Q16[i]);
	endfunction

	function automatic longint tilt_deg_q16(longint num, longint a, longint b);
		longint sq, px, py, nx, ny, ang;
		sq = a * a + b * b;
		ang = 0;
		if (sq == 0) begin
			if (num > 0) return 90 * 65536;
			if (num < 0) return -90 * 65536;
			return 0;
		end
		px = root_q8(sq <<< 16);
		py = num * 256;
		for (int i = 0; i < 16; i++) begin
			if (py > 0) begin
				nx = px + floor_shr(py, i);
				ny = py - floor_shr(px, i);
				ang += atan_q16(i);
			end else begin
				nx = px - floor_shr(py, i);
				ny = py + floor_shr(px, i);
				ang -= atan_q16(i);
			end
			px = nx;
			py = ny;
		end
		return ang;
	endfunction

	function automatic logic signed [17:0] scale_angle(longint ang, logic [9:0] g);
		longint v;
		v = floor_shr(ang * longint'(g) + 32768, 16);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return v[17:0];
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		sample_t s;
		angles_t e;
		if (start && !busy) begin
			e.pitch = scale_angle(tilt_deg_q16(accel_x, accel_y, accel_z), model_gain);
			e.roll = scale_angle(tilt_deg_q16(accel_y, accel_x, accel_z), model_gain);
			expected_angles.push_back(e);
		end
		if (start && busy) begin
			// hold the word
		end else if (gap > 0) begin
			gap <= gap - 1;
			start <= 1'b0;
		end else if (feed_on && pending_samples.size() > 0) begin
			s = pending_samples.pop_front();
			accel_x <= s.x;
			accel_y <= s.y;
			accel_z <= s.z;
			start <= 1'b1;
			gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		angles_t e;
		if (done) begin
			if (expected_angles.size() == 0) begin
				$display("%0t unexpected word: pitch %0d roll %0d", $time,
					pitch_angle, roll_angle);
				errors++;
			end else begin
				e = expected_angles.pop_front();
				if (pitch_angle !== e.pitch) begin
					$display("%0t pitch: expected %0d actual %0d", $time,
						e.pitch, pitch_angle);
					errors++;
				end
				if (roll_angle !== e.roll) begin
					$display("%0t roll: expected %0d actual %0d", $time,
						e.roll, roll_angle);
					errors++;
				end
			end
		end
	end

	task automatic add_sample(int x, int y, int z);
		sample_t s;
		s.x = 16'(x);
		s.y = 16'(y);
		s.z = 16'(z);
		pending_samples.push_back(s);
	endtask

	function automatic int rand_axis();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32767 : -32768;
			1: return int'($urandom_range(0, 8)) - 4;
			2: return int'($urandom_range(0, 600)) - 300;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	task automatic drain_and_set_gain(logic [9:0] g);
		feed_on = 1'b1;
		wait (pending_samples.size() == 0);
		@(posedge clk);
		wait (start == 1'b0 && expected_angles.size() == 0);
		feed_on = 1'b0;
		repeat (LATENCY + 5) @(posedge clk);
		gain_we <= 1'b1;
		gain_wdata <= g;
		model_gain = g;
		@(posedge clk);
		gain_we <= 1'b0;
	endtask

	initial begin
		logic [9:0] gains[5];
		model_gain = atl_pkg::GAIN_RESET;
		gains = '{10'd1023, 10'd0, 10'd256, 10'd1, 10'd358};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_sample(0, 0, 0);
		add_sample(5, 0, 0);
		add_sample(-5, 0, 0);
		add_sample(0, 7, 0);
		add_sample(0, -7, 0);
		add_sample(32767, 32767, 32767);
		add_sample(-32768, -32768, -32768);
		add_sample(-32768, 0, 0);
		add_sample(32767, 0, 0);
		add_sample(0, 0, -32768);
		add_sample(0, 0, 32767);
		add_sample(1, 1, 1);
		add_sample(-1, -1, -1);
		add_sample(16384, -16384, 1000);
		add_sample(-32768, 32767, 1);
		add_sample(100, -200, 16384);
		for (int i = 0; i < RANDOM_WORDS / 6; i++)
			add_sample(rand_axis(), rand_axis(), rand_axis());

		foreach (gains[k]) begin
			drain_and_set_gain(gains[k]);
			add_sample(32767, -32768, 0);
			add_sample(0, 0, 0);
			add_sample(-3, 3, 0);
			for (int i = 0; i < RANDOM_WORDS / 6; i++)
				add_sample(rand_axis(), rand_axis(), rand_axis());
			if (k == 1) begin
				drain_and_set_gain(10'($urandom));
				for (int i = 0; i < 20; i++)
					add_sample(rand_axis(), rand_axis(), rand_axis());
			end
		end

		feed_on = 1'b1;
		wait (pending_samples.size() == 0);
		@(posedge clk);
		wait (start == 1'b0 && expected_angles.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
